// ===== rtl/pscf_pkg.sv =====
// ----------------------------------------------------------------------------
// pscf_pkg
// Shared types and constants for the palette special-color finder.
// ----------------------------------------------------------------------------
package pscf_pkg;

	// palette geometry
	localparam int PALETTE_DEPTH = 256;
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
	localparam int IDX_W         = 8;
	localparam int COMP_W        = 8;
	localparam int SUM_W         = 10;

	// configuration port
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_TWO_COLOR     = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_PALETTE_KNOWN = 1'd1;

	// scan constants
	localparam logic [SUM_W-1:0] SUM_INIT   = '1;
	localparam logic [SUM_W-1:0] BAND_LO    = SUM_W'(80);
	localparam logic [SUM_W-1:0] BAND_HI    = SUM_W'(150);
	localparam logic [IDX_W-1:0] DARK_DEF   = IDX_W'(0);
	localparam logic [IDX_W-1:0] BRIGHT_DEF = IDX_W'(15);
	localparam logic [IDX_W-1:0] MEDIUM_DEF = IDX_W'(7);

	// fixed indices in two-color mode
	localparam logic [IDX_W-1:0] TWO_DARK   = IDX_W'(0);
	localparam logic [IDX_W-1:0] TWO_BRIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] TWO_MEDIUM = IDX_W'(1);

	typedef struct packed {
		logic             two_color;
		logic             known;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] score;
		logic             in_band;
	} metrics_t;

	typedef struct packed {
		logic [IDX_W-1:0] dark;
		logic [IDX_W-1:0] bright;
		logic [IDX_W-1:0] mid;
	} result_t;

endpackage

// ===== rtl/pscf_cfg.sv =====
// ----------------------------------------------------------------------------
// pscf_cfg
// APB-style register file: two-color mode and palette-known flags.
// ----------------------------------------------------------------------------
module pscf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pscf_pkg::ADDR_W-1:0] paddr,
	input  logic [pscf_pkg::DATA_W-1:0] pwdata,
	output logic [pscf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output pscf_pkg::cfg_t              cfg
);

	logic                           wr_en;
	logic [pscf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           two_color_q;
	logic                           known_q;

	// word-aligned register select
	assign reg_idx = paddr[pscf_pkg::ADDR_W-1 -: pscf_pkg::REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_color_q <= 1'b0;
			known_q     <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				pscf_pkg::REG_TWO_COLOR:     two_color_q <= pwdata[0];
				pscf_pkg::REG_PALETTE_KNOWN: known_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pscf_pkg::REG_TWO_COLOR:     prdata[0] = two_color_q;
			pscf_pkg::REG_PALETTE_KNOWN: prdata[0] = known_q;
			default: ;
		endcase
	end

	assign cfg.two_color = two_color_q;
	assign cfg.known     = known_q;

endmodule

// ===== rtl/pscf_eval.sv =====
// ----------------------------------------------------------------------------
// pscf_eval
// Per-entry metrics: component sum, grey score and medium-band check.
// ----------------------------------------------------------------------------
module pscf_eval (
	input  logic [pscf_pkg::COMP_W-1:0] red,
	input  logic [pscf_pkg::COMP_W-1:0] green,
	input  logic [pscf_pkg::COMP_W-1:0] blue,
	output pscf_pkg::metrics_t          metrics
);

	logic [pscf_pkg::COMP_W-1:0] hi_rg, lo_rg, hi, lo, spread;
	logic [pscf_pkg::SUM_W-1:0]  sum;

	// sum of the three components
	assign sum = pscf_pkg::SUM_W'(red) + pscf_pkg::SUM_W'(green)
		+ pscf_pkg::SUM_W'(blue);

	// component max / min
	assign hi_rg  = (green > red) ? green : red;
	assign lo_rg  = (green < red) ? green : red;
	assign hi     = (blue > hi_rg) ? blue : hi_rg;
	assign lo     = (blue < lo_rg) ? blue : lo_rg;
	assign spread = hi - lo;

	// score never underflows: sum >= hi >= spread
	assign metrics.sum     = sum;
	assign metrics.score   = sum - pscf_pkg::SUM_W'(spread >> 1);
	assign metrics.in_band = (sum > pscf_pkg::BAND_LO) && (sum < pscf_pkg::BAND_HI);

endmodule

// ===== rtl/pscf_scan.sv =====
// ----------------------------------------------------------------------------
// pscf_scan
// Running scan state: darkest, brightest and medium entries of the palette.
// ----------------------------------------------------------------------------
module pscf_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic               last,
	input  pscf_pkg::metrics_t metrics,
	input  pscf_pkg::cfg_t     cfg,
	output pscf_pkg::result_t  result
);

	logic [pscf_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [pscf_pkg::SUM_W-1:0] max_sum_q, max_sum_d;
	logic [pscf_pkg::SUM_W-1:0] min_sum_q, min_sum_d;
	logic [pscf_pkg::SUM_W-1:0] best_q, best_d;
	logic [pscf_pkg::IDX_W-1:0] dark_q, dark_d;
	logic [pscf_pkg::IDX_W-1:0] bright_q, bright_d;
	logic [pscf_pkg::IDX_W-1:0] medium_q, medium_d;
	logic [pscf_pkg::IDX_W-1:0] idx;
	logic                       in_scope;

	assign in_scope = cnt_q < pscf_pkg::CNT_W'(pscf_pkg::PALETTE_DEPTH);
	assign idx      = cnt_q[pscf_pkg::IDX_W-1:0];

	// fold the current entry into the running state
	always_comb begin
		cnt_d     = cnt_q;
		max_sum_d = max_sum_q;
		min_sum_d = min_sum_q;
		best_d    = best_q;
		dark_d    = dark_q;
		bright_d  = bright_q;
		medium_d  = medium_q;
		if (in_scope) begin
			cnt_d = cnt_q + 1'b1;
			if (metrics.sum > max_sum_q) begin
				max_sum_d = metrics.sum;
				bright_d  = idx;
			end
			if (metrics.sum < min_sum_q) begin
				min_sum_d = metrics.sum;
				dark_d    = idx;
			end
			if (metrics.in_band && (metrics.score > best_q)) begin
				best_d   = metrics.score;
				medium_d = idx;
			end
		end
	end

	// result selection; two-color mode wins over unknown palette
	always_comb begin
		priority if (cfg.two_color) begin
			result.dark   = pscf_pkg::TWO_DARK;
			result.bright = pscf_pkg::TWO_BRIGHT;
			result.mid    = pscf_pkg::TWO_MEDIUM;
		end else if (!cfg.known) begin
			result.dark   = pscf_pkg::DARK_DEF;
			result.bright = pscf_pkg::BRIGHT_DEF;
			result.mid    = pscf_pkg::MEDIUM_DEF;
		end else begin
			result.dark   = dark_d;
			result.bright = bright_d;
			result.mid    = medium_d;
		end
	end

	// state update; last entry clears for the next scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			max_sum_q <= '0;
			min_sum_q <= pscf_pkg::SUM_INIT;
			best_q    <= '0;
			dark_q    <= pscf_pkg::DARK_DEF;
			bright_q  <= pscf_pkg::BRIGHT_DEF;
			medium_q  <= pscf_pkg::MEDIUM_DEF;
		end else if (upd) begin
			if (last) begin
				cnt_q     <= '0;
				max_sum_q <= '0;
				min_sum_q <= pscf_pkg::SUM_INIT;
				best_q    <= '0;
				dark_q    <= pscf_pkg::DARK_DEF;
				bright_q  <= pscf_pkg::BRIGHT_DEF;
				medium_q  <= pscf_pkg::MEDIUM_DEF;
			end else begin
				cnt_q     <= cnt_d;
				max_sum_q <= max_sum_d;
				min_sum_q <= min_sum_d;
				best_q    <= best_d;
				dark_q    <= dark_d;
				bright_q  <= bright_d;
				medium_q  <= medium_d;
			end
		end
	end

endmodule

// ===== rtl/palette_special_color_finder.sv =====
// Palette special-color finder. Palette entries stream in one item per
// cycle unless a final item is held, indexed from zero in arrival order;
// entries past the palette depth are ignored except for their last mark.
// The item marked final_entry yields one result (darkest, brightest and
// most grey medium entry): out_valid rises once the item has passed the
// input register and the result register. With out_ready high the block
// takes a new item every cycle, and a final item waits in the input
// register only while an earlier result is still unaccepted. The two mode
// registers are read when the final entry is processed.
// ----------------------------------------------------------------------------
// palette_special_color_finder
// Top level: input register, scan stage, result register and APB port.
// ----------------------------------------------------------------------------
module palette_special_color_finder (
	input  logic                        clk,
	input  logic                        arst_n,
	// entry channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pscf_pkg::COMP_W-1:0] red,
	input  logic [pscf_pkg::COMP_W-1:0] green,
	input  logic [pscf_pkg::COMP_W-1:0] blue,
	input  logic                        final_entry,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pscf_pkg::IDX_W-1:0]  dark_index,
	output logic [pscf_pkg::IDX_W-1:0]  bright_index,
	output logic [pscf_pkg::IDX_W-1:0]  medium_index,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pscf_pkg::ADDR_W-1:0] paddr,
	input  logic [pscf_pkg::DATA_W-1:0] pwdata,
	output logic [pscf_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	logic                        valid_s1;
	logic [pscf_pkg::COMP_W-1:0] red_s1, green_s1, blue_s1;
	logic                        final_s1;
	logic                        adv_s1;
	logic                        out_valid_q;
	pscf_pkg::result_t           res_q;
	pscf_pkg::result_t           result;
	pscf_pkg::metrics_t          metrics;
	pscf_pkg::cfg_t              cfg;

	// stage 1 moves on unless it holds a final item and the result is stuck
	assign adv_s1   = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			final_s1 <= final_entry;
		end
	end

	pscf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pscf_eval u_eval (
		.red     (red_s1),
		.green   (green_s1),
		.blue    (blue_s1),
		.metrics (metrics)
	);

	pscf_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (adv_s1),
		.last    (final_s1),
		.metrics (metrics),
		.cfg     (cfg),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			res_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign dark_index   = res_q.dark;
	assign bright_index = res_q.bright;
	assign medium_index = res_q.mid;

endmodule

// ===== rtl/pscf_checker.sv =====
// ----------------------------------------------------------------------------
// pscf_checker
// Port-level checks for the palette special-color finder.
// ----------------------------------------------------------------------------
module pscf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [pscf_pkg::IDX_W-1:0] dark_index,
	input logic [pscf_pkg::IDX_W-1:0] bright_index,
	input logic [pscf_pkg::IDX_W-1:0] medium_index,
	input logic                       psel,
	input logic                       pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dark_index)
			&& $stable(bright_index) && $stable(medium_index))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled result
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a stalled result");

	// no result once reset has been seen at a clock edge
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("out_valid high in reset");

	// register port never inserts wait states
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low on a selected access");

endmodule

bind palette_special_color_finder pscf_checker u_pscf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.dark_index   (dark_index),
	.bright_index (bright_index),
	.medium_index (medium_index),
	.psel         (psel),
	.pready       (pready)
);

// ===== verif/palette_special_color_finder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_special_color_finder_tb
// Self-checking bench for the palette special-color finder. Palette scans
// are queued as items and streamed through the entry channel with random
// gaps, while the result channel stalls at random. A scan model tracks the
// darkest, brightest and most grey entry of each scan and predicts every
// result; the mode registers are rewritten over APB between phases and read
// back.
// ----------------------------------------------------------------------------
module palette_special_color_finder_tb;

	localparam int CLK_HALF   = 6;
	localparam int CYCLE_CAP  = 400000;
	localparam int DRAIN_WAIT = 8;

	typedef struct packed {
		logic [pscf_pkg::COMP_W-1:0] r;
		logic [pscf_pkg::COMP_W-1:0] g;
		logic [pscf_pkg::COMP_W-1:0] b;
		logic                        last;
	} entry_t;

	// block ports
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic [pscf_pkg::COMP_W-1:0] red         = '0;
	logic [pscf_pkg::COMP_W-1:0] green       = '0;
	logic [pscf_pkg::COMP_W-1:0] blue        = '0;
	logic                        final_entry = 1'b0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic [pscf_pkg::IDX_W-1:0]  dark_index;
	logic [pscf_pkg::IDX_W-1:0]  bright_index;
	logic [pscf_pkg::IDX_W-1:0]  medium_index;
	logic                        psel        = 1'b0;
	logic                        penable     = 1'b0;
	logic                        pwrite      = 1'b0;
	logic [pscf_pkg::ADDR_W-1:0] paddr       = '0;
	logic [pscf_pkg::DATA_W-1:0] pwdata      = '0;
	logic [pscf_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	// stimulus and scoreboard
	entry_t            pending_entries[$];
	pscf_pkg::result_t expected_indices[$];
	pscf_pkg::result_t oldest_indices;
	entry_t            next_entry;
	int                error_count = 0;
	int                cycle_count = 0;
	bit                in_accepted = 1'b0;
	bit                calm        = 1'b0;
	int                in_gap_left = 0;
	bit                in_quiet    = 1'b0;
	int                out_gap_left = 0;
	bit                out_quiet   = 1'b0;

	// scan model state
	pscf_pkg::cfg_t             mode_shadow;
	int                         scan_count;
	logic [pscf_pkg::SUM_W-1:0] peak_sum;
	logic [pscf_pkg::SUM_W-1:0] floor_sum;
	logic [pscf_pkg::SUM_W-1:0] grey_score;
	logic [pscf_pkg::IDX_W-1:0] darkest_idx;
	logic [pscf_pkg::IDX_W-1:0] brightest_idx;
	logic [pscf_pkg::IDX_W-1:0] grey_idx;

	palette_special_color_finder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.final_entry  (final_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dark_index   (dark_index),
		.bright_index (bright_index),
		.medium_index (medium_index),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// start a fresh scan
	task automatic clear_scan_model();
		scan_count    = 0;
		peak_sum      = '0;
		floor_sum     = pscf_pkg::SUM_INIT;
		grey_score    = '0;
		darkest_idx   = pscf_pkg::DARK_DEF;
		brightest_idx = pscf_pkg::BRIGHT_DEF;
		grey_idx      = pscf_pkg::MEDIUM_DEF;
	endtask

	// fold one accepted entry into the scan; the last mark yields a result
	task automatic absorb_entry(input entry_t e);
		logic [pscf_pkg::SUM_W-1:0]  entry_sum;
		logic [pscf_pkg::SUM_W-1:0]  score;
		logic [pscf_pkg::COMP_W-1:0] hi;
		logic [pscf_pkg::COMP_W-1:0] lo;
		pscf_pkg::result_t           res;
		if (scan_count < pscf_pkg::PALETTE_DEPTH) begin
			entry_sum = pscf_pkg::SUM_W'(e.r) + pscf_pkg::SUM_W'(e.g)
				+ pscf_pkg::SUM_W'(e.b);
			if (entry_sum > peak_sum) begin
				peak_sum      = entry_sum;
				brightest_idx = pscf_pkg::IDX_W'(scan_count);
			end
			if (entry_sum < floor_sum) begin
				floor_sum   = entry_sum;
				darkest_idx = pscf_pkg::IDX_W'(scan_count);
			end
			// grey score only counts inside the medium band
			if (entry_sum > pscf_pkg::BAND_LO && entry_sum < pscf_pkg::BAND_HI) begin
				hi = e.r;
				lo = e.r;
				if (e.g > hi) hi = e.g;
				if (e.g < lo) lo = e.g;
				if (e.b > hi) hi = e.b;
				if (e.b < lo) lo = e.b;
				score = entry_sum - (pscf_pkg::SUM_W'(hi - lo) >> 1);
				if (score > grey_score) begin
					grey_score = score;
					grey_idx   = pscf_pkg::IDX_W'(scan_count);
				end
			end
			scan_count++;
		end
		if (e.last) begin
			if (mode_shadow.two_color) begin
				res = '{dark: pscf_pkg::TWO_DARK, bright: pscf_pkg::TWO_BRIGHT,
					mid: pscf_pkg::TWO_MEDIUM};
			end else if (!mode_shadow.known) begin
				res = '{dark: pscf_pkg::DARK_DEF, bright: pscf_pkg::BRIGHT_DEF,
					mid: pscf_pkg::MEDIUM_DEF};
			end else begin
				res = '{dark: darkest_idx, bright: brightest_idx, mid: grey_idx};
			end
			expected_indices.push_back(res);
			clear_scan_model();
		end
	endtask

	// accept-side sampling, prediction and result checking
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end else begin
			in_accepted = arst_n && in_valid && in_ready;
			if (in_accepted)
				absorb_entry('{r: red, g: green, b: blue, last: final_entry});
			if (arst_n && out_valid && out_ready) begin
				if (expected_indices.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d %0d %0d",
						dark_index, bright_index, medium_index));
				end else begin
					oldest_indices = expected_indices.pop_front();
					if (dark_index !== oldest_indices.dark)
						report_mismatch($sformatf("dark_index %0d, expected %0d",
							dark_index, oldest_indices.dark));
					if (bright_index !== oldest_indices.bright)
						report_mismatch($sformatf("bright_index %0d, expected %0d",
							bright_index, oldest_indices.bright));
					if (medium_index !== oldest_indices.mid)
						report_mismatch($sformatf("medium_index %0d, expected %0d",
							medium_index, oldest_indices.mid));
				end
			end
		end
	end

	// entry driver: holds an item until accepted, idles in random bursts
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
			if (in_gap_left > 0 && !calm) begin
				in_gap_left--;
				in_valid <= 1'b0;
			end else if (!calm && !in_quiet && $urandom_range(0, 5) == 0) begin
				in_gap_left = $urandom_range(1, 6) - 1;
				in_valid <= 1'b0;
			end else if (pending_entries.size() != 0) begin
				next_entry = pending_entries.pop_front();
				red         <= next_entry.r;
				green       <= next_entry.g;
				blue        <= next_entry.b;
				final_entry <= next_entry.last;
				in_valid    <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result-side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
			if (calm) begin
				out_ready <= 1'b1;
			end else if (out_gap_left > 0) begin
				out_gap_left--;
				out_ready <= 1'b0;
			end else if (!out_quiet && $urandom_range(0, 5) == 0) begin
				out_gap_left = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// APB write, then the register takes effect in the model
	task automatic write_register(input logic [pscf_pkg::REG_IDX_W-1:0] idx,
		input logic value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= pscf_pkg::DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == pscf_pkg::REG_TWO_COLOR) mode_shadow.two_color = value;
		else mode_shadow.known = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// APB read, compared with the register as last written
	task automatic read_register(input logic [pscf_pkg::REG_IDX_W-1:0] idx);
		logic want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = (idx == pscf_pkg::REG_TWO_COLOR) ? mode_shadow.two_color
			: mode_shadow.known;
		if (prdata !== pscf_pkg::DATA_W'(want))
			report_mismatch($sformatf("register %0d read %0h, expected %0h",
				idx, prdata, want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// everything sent and returned, plus room for a trailing non-final item
	task automatic wait_idle();
		while (pending_entries.size() != 0 || in_valid || expected_indices.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_modes(input logic two_color, input logic known);
		wait_idle();
		write_register(pscf_pkg::REG_TWO_COLOR, two_color);
		write_register(pscf_pkg::REG_PALETTE_KNOWN, known);
		read_register(pscf_pkg::REG_TWO_COLOR);
		read_register(pscf_pkg::REG_PALETTE_KNOWN);
	endtask

	function automatic logic [pscf_pkg::COMP_W-1:0] clip_comp(input int v);
		if (v < 0) return '0;
		if (v > 255) return '1;
		return pscf_pkg::COMP_W'(v);
	endfunction

	// random entry, biased toward the medium band and the extremes
	function automatic entry_t make_entry(input logic last);
		entry_t e;
		int     base;
		e.last = last;
		case ($urandom_range(0, 3))
			0: begin
				e.r = pscf_pkg::COMP_W'($urandom_range(0, 255));
				e.g = pscf_pkg::COMP_W'($urandom_range(0, 255));
				e.b = pscf_pkg::COMP_W'($urandom_range(0, 255));
			end
			1: begin
				base = int'($urandom_range(20, 55));
				e.r = clip_comp(base + int'($urandom_range(0, 16)) - 8);
				e.g = clip_comp(base + int'($urandom_range(0, 16)) - 8);
				e.b = clip_comp(base + int'($urandom_range(0, 16)) - 8);
			end
			2: begin
				e.r = pscf_pkg::COMP_W'($urandom_range(0, 10));
				e.g = pscf_pkg::COMP_W'($urandom_range(0, 10));
				e.b = pscf_pkg::COMP_W'($urandom_range(0, 10));
			end
			default: begin
				e.r = pscf_pkg::COMP_W'($urandom_range(240, 255));
				e.g = pscf_pkg::COMP_W'($urandom_range(240, 255));
				e.b = pscf_pkg::COMP_W'($urandom_range(240, 255));
			end
		endcase
		return e;
	endfunction

	// queue random scans; a scan cut off at the end carries into the next phase
	task automatic queue_scans(input int item_total, input bit with_overrun);
		int left;
		int len;
		int k;
		left = item_total;
		while (left > 0) begin
			if (with_overrun) begin
				len = $urandom_range(pscf_pkg::PALETTE_DEPTH + 1,
					pscf_pkg::PALETTE_DEPTH + 8);
				with_overrun = 1'b0;
			end else if ($urandom_range(0, 39) == 0) begin
				len = $urandom_range(pscf_pkg::PALETTE_DEPTH - 6,
					pscf_pkg::PALETTE_DEPTH + 14);
			end else begin
				len = $urandom_range(1, 24);
			end
			for (k = 0; k < len && left > 0; k++) begin
				pending_entries.push_back(make_entry(k == len - 1));
				left--;
			end
		end
	endtask

	task automatic push_entry(input int r, input int g, input int b, input logic last);
		pending_entries.push_back('{r: pscf_pkg::COMP_W'(r), g: pscf_pkg::COMP_W'(g),
			b: pscf_pkg::COMP_W'(b), last: last});
	endtask

	initial begin
		mode_shadow = '{two_color: 1'b0, known: 1'b1};
		clear_scan_model();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values, then rewrite the defaults
		read_register(pscf_pkg::REG_TWO_COLOR);
		read_register(pscf_pkg::REG_PALETTE_KNOWN);
		apply_modes(1'b0, 1'b1);

		// band edges, ties, black, white and component extremes
		push_entry(40, 40, 40, 1'b0);
		push_entry(0, 0, 0, 1'b0);
		push_entry(255, 255, 255, 1'b0);
		push_entry(27, 27, 27, 1'b0);
		push_entry(50, 50, 49, 1'b0);
		push_entry(50, 50, 50, 1'b0);
		push_entry(27, 27, 26, 1'b0);
		push_entry(0, 0, 0, 1'b0);
		push_entry(255, 255, 255, 1'b0);
		push_entry(149, 0, 0, 1'b1);
		// lone black entry keeps the bright and medium defaults
		push_entry(0, 0, 0, 1'b1);
		// equal sums keep the first index
		push_entry(255, 0, 0, 1'b0);
		push_entry(0, 255, 0, 1'b0);
		push_entry(0, 0, 255, 1'b1);
		// wide spread lowers the grey score
		push_entry(100, 40, 0, 1'b0);
		push_entry(1, 1, 1, 1'b1);

		// random scans under each mode setting, one running past the depth
		queue_scans(300, 1'b1);
		apply_modes(1'b1, 1'b1);
		queue_scans(80, 1'b0);
		apply_modes(1'b0, 1'b0);
		queue_scans(80, 1'b0);
		apply_modes(1'b1, 1'b0);
		queue_scans(80, 1'b0);
		apply_modes(1'b0, 1'b1);
		queue_scans(80, 1'b0);
		wait_idle();
		calm = 1'b1;
		queue_scans(80, 1'b0);

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_indices.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_indices.size()));
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
